// File: rtl/ilab_pkg.sv
// ----------------------------------------------------------------------------
// ilab_pkg
// Shared widths, status codes and controller/datapath command types for the
// integer logarithm unit.
// ----------------------------------------------------------------------------
package ilab_pkg;

	// Width of the input fields on the operand channel.
	localparam int FIELD_W = 32;
	// Operand width inside the datapath; inputs are masked to this width.
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	// Powers base^(2^k) for k = 0 .. NUM_POW-1 cover every exponent below DATA_W.
	localparam int NUM_POW = $clog2(DATA_W);
	localparam int K_W = (NUM_POW > 1) ? $clog2(NUM_POW) : 1;
	localparam int RESULT_W = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_BASE = 2'd1,
		ST_ZERO_ARG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_MUL,
		OP_SQ_KEEP,
		OP_ACC_INIT,
		OP_TR_MUL,
		OP_TR_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} dp_cmd_t;

	typedef struct packed {
		logic           special;
		logic           base_gt_arg;
		logic           prod_le_arg;
		logic [K_W-1:0] k;
	} dp_status_t;

endpackage

// File: rtl/ilab_ifs.sv
// ----------------------------------------------------------------------------
// ilab channel interfaces
// Valid/ready channels for the operand pair and for the logarithm result.
// ----------------------------------------------------------------------------
interface ilab_in_if;
	logic                         valid;
	logic                         ready;
	logic [ilab_pkg::FIELD_W-1:0] log_base;
	logic [ilab_pkg::FIELD_W-1:0] argument;

	modport source (output valid, output log_base, output argument, input ready);
	modport sink (input valid, input log_base, input argument, output ready);
endinterface

interface ilab_out_if;
	logic                          valid;
	logic                          ready;
	logic [ilab_pkg::RESULT_W-1:0] log_result;
	logic [ilab_pkg::STATUS_W-1:0] status;

	modport source (output valid, output log_result, output status, input ready);
	modport sink (input valid, input log_result, input status, output ready);
endinterface

// File: rtl/integer_log_any_base_unit.sv
// A bad base, a zero argument or a base above the argument goes from the check state straight
// to the done state; otherwise the squaring and trial phases come in between.
// One item at a time: the next operand transfer is taken only after the result has been
// emitted; the shared 32x32 multiplier serves each squaring or trial as a multiply step and
// then a compare step, with at most four of each per item.
// Reset (arst_n, asynchronous) returns the sequencer to idle and drops result valid.
// ----------------------------------------------------------------------------
// integer_log_any_base_unit
// Computes floor(log_base(argument)) with a status code for each operand pair.
// ----------------------------------------------------------------------------
module integer_log_any_base_unit (
	input  logic  clk,
	input  logic  arst_n,
	ilab_in_if.sink    operands,
	ilab_out_if.source result
);

	// The controller sequences the work; the datapath holds every operand,
	// the power table base^(2^k), the accumulator and the single multiplier.
	// First the base is squared while the square stays within the argument,
	// then the accumulator starts at the largest kept power and each smaller
	// power is tried in turn; a trial product that does not exceed the
	// argument is kept and sets the matching exponent bit.

	ilab_pkg::dp_cmd_t    cmd;
	ilab_pkg::dp_status_t stat;

	ilab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The result register sits in the datapath, so a finished result can
	// wait for the sink while the next operand transfer is taken.
	ilab_datapath u_dp (
		.clk        (clk),
		.log_base   (operands.log_base),
		.argument   (operands.argument),
		.cmd        (cmd),
		.stat       (stat),
		.log_result (result.log_result),
		.status     (result.status)
	);

endmodule

// File: rtl/ilab_datapath.sv
// ----------------------------------------------------------------------------
// ilab_datapath
// Power table, accumulator, shared multiplier and result register.
// ----------------------------------------------------------------------------
module ilab_datapath (
	input  logic                          clk,
	input  logic [ilab_pkg::FIELD_W-1:0]  log_base,
	input  logic [ilab_pkg::FIELD_W-1:0]  argument,
	input  ilab_pkg::dp_cmd_t             cmd,
	output ilab_pkg::dp_status_t          stat,
	output logic [ilab_pkg::RESULT_W-1:0] log_result,
	output logic [ilab_pkg::STATUS_W-1:0] status
);

	logic [ilab_pkg::DATA_W-1:0]  pow_q [ilab_pkg::NUM_POW];
	logic [ilab_pkg::DATA_W-1:0]  arg_q;
	logic [ilab_pkg::DATA_W-1:0]  acc_q;
	logic [ilab_pkg::PROD_W-1:0]  prod_q;
	logic [ilab_pkg::NUM_POW-1:0] n_q;
	logic [ilab_pkg::K_W-1:0]     k_q;
	ilab_pkg::status_t            st_q;
	logic [ilab_pkg::RESULT_W-1:0] res_out_q;
	ilab_pkg::status_t            st_out_q;

	logic [ilab_pkg::DATA_W-1:0] base_in;
	logic [ilab_pkg::DATA_W-1:0] arg_in;
	logic [ilab_pkg::DATA_W-1:0] pow_rd;
	logic [ilab_pkg::DATA_W-1:0] mul_a;
	logic [ilab_pkg::PROD_W-1:0] mul_p;
	ilab_pkg::status_t           st_in;

	assign base_in = ilab_pkg::DATA_W'(log_base);
	assign arg_in  = ilab_pkg::DATA_W'(argument);
	assign pow_rd  = pow_q[k_q];
	assign mul_a   = (cmd.op == ilab_pkg::OP_TR_MUL) ? acc_q : pow_rd;
	assign mul_p   = ilab_pkg::PROD_W'(mul_a) * ilab_pkg::PROD_W'(pow_rd);

	always_comb begin
		if (base_in < ilab_pkg::DATA_W'(2)) begin
			st_in = ilab_pkg::ST_BAD_BASE;
		end else if (arg_in == '0) begin
			st_in = ilab_pkg::ST_ZERO_ARG;
		end else begin
			st_in = ilab_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ilab_pkg::OP_LOAD: begin
				pow_q[0] <= base_in;
				arg_q    <= arg_in;
				st_q     <= st_in;
				k_q      <= '0;
				n_q      <= '0;
			end
			ilab_pkg::OP_SQ_MUL, ilab_pkg::OP_TR_MUL: begin
				prod_q <= mul_p;
			end
			ilab_pkg::OP_SQ_KEEP: begin
				pow_q[k_q + ilab_pkg::K_W'(1)] <= prod_q[ilab_pkg::DATA_W-1:0];
				k_q <= k_q + ilab_pkg::K_W'(1);
			end
			ilab_pkg::OP_ACC_INIT: begin
				acc_q    <= pow_rd;
				n_q[k_q] <= 1'b1;
				if (k_q != '0) begin
					k_q <= k_q - ilab_pkg::K_W'(1);
				end
			end
			ilab_pkg::OP_TR_STEP: begin
				if (stat.prod_le_arg) begin
					acc_q    <= prod_q[ilab_pkg::DATA_W-1:0];
					n_q[k_q] <= 1'b1;
				end
				if (k_q != '0) begin
					k_q <= k_q - ilab_pkg::K_W'(1);
				end
			end
			ilab_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase

		if (cmd.emit) begin
			res_out_q <= ilab_pkg::RESULT_W'(n_q);
			st_out_q  <= st_q;
		end
	end

	assign stat.special     = (st_q != ilab_pkg::ST_OK);
	assign stat.base_gt_arg = (pow_rd > arg_q);
	assign stat.prod_le_arg = (prod_q <= ilab_pkg::PROD_W'(arg_q));
	assign stat.k           = k_q;

	assign log_result = res_out_q;
	assign status     = st_out_q;

endmodule

// File: rtl/ilab_ctrl.sv
// ----------------------------------------------------------------------------
// ilab_ctrl
// Sequencer for the squaring and trial-multiply phases and the result handshake.
// ----------------------------------------------------------------------------
module ilab_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ilab_pkg::dp_status_t stat,
	output ilab_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SQ_MUL,
		S_SQ_CMP,
		S_ACC_INIT,
		S_TR_MUL,
		S_TR_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit;

	assign in_ready  = (state_q == S_IDLE);
	assign emit      = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.emit = emit;
		unique case (state_q)
			S_IDLE:     cmd.op = in_valid ? ilab_pkg::OP_LOAD : ilab_pkg::OP_NONE;
			S_SQ_MUL:   cmd.op = ilab_pkg::OP_SQ_MUL;
			S_SQ_CMP:   cmd.op = stat.prod_le_arg ? ilab_pkg::OP_SQ_KEEP : ilab_pkg::OP_NONE;
			S_ACC_INIT: cmd.op = ilab_pkg::OP_ACC_INIT;
			S_TR_MUL:   cmd.op = ilab_pkg::OP_TR_MUL;
			S_TR_CMP:   cmd.op = ilab_pkg::OP_TR_STEP;
			default:    cmd.op = ilab_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Bad base, zero argument or a base above the argument end here.
					if (stat.special || stat.base_gt_arg) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SQ_MUL;
					end
				end
				S_SQ_MUL: begin
					state_q <= S_SQ_CMP;
				end
				S_SQ_CMP: begin
					if (stat.prod_le_arg &&
					    (stat.k != ilab_pkg::K_W'(ilab_pkg::NUM_POW - 2))) begin
						state_q <= S_SQ_MUL;
					end else begin
						state_q <= S_ACC_INIT;
					end
				end
				S_ACC_INIT, S_TR_CMP: begin
					if (stat.k == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_TR_MUL;
					end
				end
				S_TR_MUL: begin
					state_q <= S_TR_CMP;
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/ilab_checker.sv
// ----------------------------------------------------------------------------
// ilab_checker
// Port-level checks of the integer logarithm unit, bound to the top level.
// ----------------------------------------------------------------------------
module ilab_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ilab_pkg::RESULT_W-1:0] log_result,
	input logic [ilab_pkg::STATUS_W-1:0] status
);

	// A result that is held back stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(log_result) && $stable(status))
		else $error("result changed while stalled");

	// Only one item is in work: after a transfer the operand side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("operand taken while an item is in work");

	// A result never appears sooner than the shortest path.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !$rose(out_valid))
		else $error("result appeared too early");

	// Only defined status codes, and a zero logarithm on any failure.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ilab_pkg::ST_OK) ||
		              ((status == ilab_pkg::ST_BAD_BASE || status == ilab_pkg::ST_ZERO_ARG)
		               && (log_result == '0)))
		else $error("bad status or nonzero result on failure");

endmodule

bind integer_log_any_base_unit ilab_checker u_ilab_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (operands.valid),
	.in_ready   (operands.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.log_result (result.log_result),
	.status     (result.status)
);
